/* rtl/tkr_pkg.sv */
// Shared types and codes for the top-k hit ranker.
// No dependencies; imported by tkr_cell and top_k_hit_ranker_top.
`default_nettype none

package tkr_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned RANK_W  = 6;

    typedef struct packed {
        logic [31:0] document;
        logic [7:0]  matched;
        logic [31:0] importance;
    } entry_t;

endpackage : tkr_pkg

`default_nettype wire

/* rtl/top_k_hit_ranker_top.sv */
// Top level of the top-k hit ranker: handshakes, count, limit register and read-out sequencer.
// Depends on tkr_pkg and tkr_cell.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------------------
//  s_        | in        | s_valid / s_ready     | action, document, matched, importance
//  m_        | out       | m_valid / m_ready     | hit_valid, rank, hit_*, held, accepted, last
//  cfg_      | in        | cfg_valid / cfg_ready | hit_limit (7 bits)
//
// Clear, insert and unused action words are handled in ST_IDLE: the chain of cells compares
// every entry with the candidate in parallel and shifts in the same edge, so a stream of
// inserts runs at one word per cycle while the output register drains.
// A read-out gives one held hit per cycle through the output register while it drains.
// Reset (aresetn low, synchronous) empties the list and sets the limit to 16; entries need
// no clearing since only the first count slots are ever read.
// A stall on m_ready holds the output register; s_ready drops until it frees.
`default_nettype none

module top_k_hit_ranker_top #(
    parameter int unsigned MAX_HITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input words
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_action,
    input  wire logic [31:0]                    s_document,
    input  wire logic [7:0]                     s_matched,
    input  wire logic [31:0]                    s_importance,
    // result words
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_hit_valid,
    output logic [tkr_pkg::RANK_W-1:0]          m_rank,
    output logic [31:0]                         m_hit_document,
    output logic [7:0]                          m_hit_matched,
    output logic [31:0]                         m_hit_importance,
    output logic [tkr_pkg::LIMIT_W-1:0]         m_held,
    output logic                                m_accepted,
    output logic                                m_last,
    // configuration
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tkr_pkg::LIMIT_W-1:0]    cfg_hit_limit
);
    import tkr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_HITS + 1);
    localparam int unsigned IDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam logic [LIMIT_W-1:0] MAX_LIM = LIMIT_W'(MAX_HITS);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_hit_valid_reg, m_hit_valid_next;
    logic [RANK_W-1:0]   m_rank_reg, m_rank_next;
    entry_t              m_hit_reg, m_hit_next;
    logic [LIMIT_W-1:0]  m_held_reg, m_held_next;
    logic                m_accepted_reg, m_accepted_next;
    logic                m_last_reg, m_last_next;

    logic [CNT_W-1:0]    eff_limit;
    logic [CNT_W-1:0]    cfg_eff_limit;
    logic                out_free;
    logic                in_fire;
    logic                insert_en;
    logic                drop;
    logic                rd_last;

    entry_t              cand;
    entry_t              cells  [MAX_HITS];
    logic [MAX_HITS-1:0] keep_vec;
    logic [MAX_HITS-1:0] live_vec;

    // Saturate the limit to the built depth
    assign eff_limit     = (limit_reg > MAX_LIM) ? CNT_W'(MAX_HITS) : CNT_W'(limit_reg);
    assign cfg_eff_limit = (cfg_hit_limit > MAX_LIM) ? CNT_W'(MAX_HITS) : CNT_W'(cfg_hit_limit);

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;

    assign cand.document   = s_document;
    assign cand.matched    = s_matched;
    assign cand.importance = s_importance;

    // Chain of cells: each slot sees its left neighbour's entry and keep flag
    for (genvar i = 0; i < MAX_HITS; i++) begin : g_cell
        assign live_vec[i] = (CNT_W'(i) < count_reg);
        if (i == 0) begin : g_head
            tkr_cell u_cell (
                .aclk       (aclk),
                .insert_en  (insert_en),
                .live       (live_vec[i]),
                .cand       (cand),
                .left_entry (cand),
                .left_keep  (1'b1),
                .entry      (cells[i]),
                .keep       (keep_vec[i])
            );
        end else begin : g_body
            tkr_cell u_cell (
                .aclk       (aclk),
                .insert_en  (insert_en),
                .live       (live_vec[i]),
                .cand       (cand),
                .left_entry (cells[i-1]),
                .left_keep  (keep_vec[i-1]),
                .entry      (cells[i]),
                .keep       (keep_vec[i])
            );
        end
    end

    // Drop when full and every held entry is at least as heavy (covers a zero limit too)
    assign drop    = (count_reg == eff_limit) && (&(keep_vec | ~live_vec));
    assign rd_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        limit_next       = limit_reg;
        rd_idx_next      = rd_idx_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_hit_valid_next = m_hit_valid_reg;
        m_rank_next      = m_rank_reg;
        m_hit_next       = m_hit_reg;
        m_held_next      = m_held_reg;
        m_accepted_next  = m_accepted_reg;
        m_last_next      = m_last_reg;
        insert_en        = 1'b0;

        // Lowering the limit cuts the lightest entries off
        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_hit_limit;
            if (count_reg > cfg_eff_limit) begin
                count_next = cfg_eff_limit;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    m_valid_next     = 1'b1;
                    m_hit_valid_next = 1'b0;
                    m_rank_next      = '0;
                    m_hit_next       = '0;
                    m_held_next      = LIMIT_W'(count_reg);
                    m_accepted_next  = 1'b0;
                    m_last_next      = 1'b1;
                    case (s_action)
                        ACT_CLEAR: begin
                            count_next  = '0;
                            m_held_next = '0;
                        end
                        ACT_INSERT: begin
                            if (!drop) begin
                                insert_en       = 1'b1;
                                m_accepted_next = 1'b1;
                                if (count_reg < eff_limit) begin
                                    count_next  = count_reg + CNT_W'(1);
                                    m_held_next = LIMIT_W'(count_reg) + LIMIT_W'(1);
                                end
                            end
                        end
                        ACT_READ: begin
                            if (count_reg != '0) begin
                                m_hit_valid_next = 1'b1;
                                m_hit_next       = cells[0];
                                m_last_next      = (count_reg == CNT_W'(1));
                                if (count_reg != CNT_W'(1)) begin
                                    state_next  = ST_READ;
                                    rd_idx_next = IDX_W'(1);
                                end
                            end
                        end
                        default: begin
                            // unused code: status word only
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_hit_valid_next = 1'b1;
                    m_rank_next      = RANK_W'(rd_idx_reg);
                    m_hit_next       = cells[rd_idx_reg];
                    m_held_next      = LIMIT_W'(count_reg);
                    m_accepted_next  = 1'b0;
                    m_last_next      = rd_last;
                    rd_idx_next      = rd_idx_reg + IDX_W'(1);
                    if (rd_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_hit_valid_reg <= m_hit_valid_next;
        m_rank_reg      <= m_rank_next;
        m_hit_reg       <= m_hit_next;
        m_held_reg      <= m_held_next;
        m_accepted_reg  <= m_accepted_next;
        m_last_reg      <= m_last_next;
        rd_idx_reg      <= rd_idx_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            limit_reg   <= LIMIT_W'(16);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit_valid      = m_hit_valid_reg;
    assign m_rank           = m_rank_reg;
    assign m_hit_document   = m_hit_reg.document;
    assign m_hit_matched    = m_hit_reg.matched;
    assign m_hit_importance = m_hit_reg.importance;
    assign m_held           = m_held_reg;
    assign m_accepted       = m_accepted_reg;
    assign m_last           = m_last_reg;

    // The list never grows past the saturated limit
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= eff_limit)
        else $error("hit count above effective limit");

    // A hit word always ranks inside the held list
    a_rank_inside : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit_valid) |-> (LIMIT_W'(m_rank) < m_held))
        else $error("emitted rank outside held list");

    // An insert or status word is always a single, final word
    a_status_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit_valid) |-> m_last)
        else $error("status word without last");

    // Read-out sequencer never runs while the list is empty
    a_read_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (count_reg != '0))
        else $error("read-out running on empty list");

endmodule : top_k_hit_ranker_top

`default_nettype wire

/* rtl/tkr_cell.sv */
// One slot of the sorted hit chain: holds an entry, or takes the candidate or its left neighbour.
// Depends on tkr_pkg for entry_t.
`default_nettype none

module tkr_cell (
    input  wire logic            aclk,
    input  wire logic            insert_en,
    input  wire logic            live,
    input  wire tkr_pkg::entry_t cand,
    input  wire tkr_pkg::entry_t left_entry,
    input  wire logic            left_keep,
    output tkr_pkg::entry_t      entry,
    output logic                 keep
);
    import tkr_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Hold when this entry is live and at least as heavy as the candidate
    assign keep = live && (entry_reg.importance >= cand.importance);

    always_comb begin
        entry_next = entry_reg;
        if (insert_en && !keep) begin
            if (left_keep) begin
                entry_next = cand;
            end else begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule : tkr_cell

`default_nettype wire

/* tb/top_k_hit_ranker_top_tb.sv */
// Self-checking testbench for top_k_hit_ranker_top: directed and random words, several limits.
// Depends on tkr_pkg and the ranker RTL; needs no files or arguments.
// A scoreboard of expected result words is filled by an in-bench ranked-list predictor.
module top_k_hit_ranker_top_tb;
    import tkr_pkg::*;

    localparam int unsigned MAX_HITS    = 16;
    localparam logic [1:0]  ACT_SPARE   = 2'd3;   // unused action code, answered with status
    localparam int          QUIET_LIMIT = 2000;   // cycles without any handshake
    localparam int          HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int          SETTLE      = 5;      // pause before a limit write and at the end

    typedef struct {
        logic [1:0]  action;
        logic [31:0] document;
        logic [7:0]  matched;
        logic [31:0] importance;
    } pending_word_t;

    typedef struct {
        logic               hit_valid;
        logic [RANK_W-1:0]  rank;
        logic [31:0]        document;
        logic [7:0]         matched;
        logic [31:0]        importance;
        logic [LIMIT_W-1:0] held;
        logic               accepted;
        logic               last;
    } ranked_word_t;

    logic                aclk;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [1:0]          s_action         = ACT_CLEAR;
    logic [31:0]         s_document       = '0;
    logic [7:0]          s_matched        = '0;
    logic [31:0]         s_importance     = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic                m_hit_valid;
    logic [RANK_W-1:0]   m_rank;
    logic [31:0]         m_hit_document;
    logic [7:0]          m_hit_matched;
    logic [31:0]         m_hit_importance;
    logic [LIMIT_W-1:0]  m_held;
    logic                m_accepted;
    logic                m_last;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_hit_limit    = 7'd16;

    pending_word_t pending_words[$];
    ranked_word_t  expected_words[$];

    // Predictor state: held list, heaviest first, and the limit register
    entry_t             ranked_list [MAX_HITS];
    int unsigned        held_count  = 0;
    logic [LIMIT_W-1:0] limit_reg   = 7'd16;

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    int  hold_seq       = 0;
    int  hold_seen      = 0;
    bit  s_gaps_on      = 1'b1;
    bit  m_gaps_on      = 1'b1;

    top_k_hit_ranker_top #(
        .MAX_HITS (MAX_HITS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_document       (s_document),
        .s_matched        (s_matched),
        .s_importance     (s_importance),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit_valid      (m_hit_valid),
        .m_rank           (m_rank),
        .m_hit_document   (m_hit_document),
        .m_hit_matched    (m_hit_matched),
        .m_hit_importance (m_hit_importance),
        .m_held           (m_held),
        .m_accepted       (m_accepted),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_hit_limit    (cfg_hit_limit)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Limits above the built depth saturate to it
    function automatic int unsigned list_cap();
        return (limit_reg > MAX_HITS) ? MAX_HITS : int'(limit_reg);
    endfunction

    // Write the limit and cut the list to it, dropping the lightest entries
    function automatic void apply_limit(input logic [LIMIT_W-1:0] value);
        limit_reg = value;
        if (held_count > list_cap())
            held_count = list_cap();
    endfunction

    // Place a candidate behind every entry of equal or greater importance
    function automatic bit insert_hit(input logic [31:0] doc, input logic [7:0] mt,
                                      input logic [31:0] imp);
        int unsigned cap;
        int unsigned pos;
        cap = list_cap();
        if (cap == 0)
            return 1'b0;
        if (held_count > cap)
            held_count = cap;
        // a full list only takes something strictly heavier than its lightest entry
        if (held_count == cap && ranked_list[cap-1].importance >= imp)
            return 1'b0;
        pos = (held_count < cap) ? held_count : cap - 1;
        while (pos > 0 && ranked_list[pos-1].importance < imp) begin
            ranked_list[pos] = ranked_list[pos-1];
            pos--;
        end
        ranked_list[pos] = '{document: doc, matched: mt, importance: imp};
        if (held_count < cap)
            held_count++;
        return 1'b1;
    endfunction

    // Work out the result words of one accepted input word
    function automatic void rank_word(input pending_word_t w);
        ranked_word_t r;
        r = '{default: '0};
        r.last = 1'b1;
        case (w.action)
            ACT_CLEAR: begin
                held_count = 0;
                expected_words.push_back(r);
            end
            ACT_INSERT: begin
                r.accepted = insert_hit(w.document, w.matched, w.importance);
                r.held     = LIMIT_W'(held_count);
                expected_words.push_back(r);
            end
            ACT_READ: begin
                r.held = LIMIT_W'(held_count);
                if (held_count == 0) begin
                    expected_words.push_back(r);
                end else begin
                    for (int unsigned i = 0; i < held_count; i++) begin
                        r.hit_valid  = 1'b1;
                        r.rank       = RANK_W'(i);
                        r.document   = ranked_list[i].document;
                        r.matched    = ranked_list[i].matched;
                        r.importance = ranked_list[i].importance;
                        r.last       = (i + 1 == held_count);
                        expected_words.push_back(r);
                    end
                end
            end
            default: begin
                // unused code: status only, list untouched
                r.held = LIMIT_W'(held_count);
                expected_words.push_back(r);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void queue_word(input logic [1:0] act, input logic [31:0] doc,
                                       input logic [7:0] mt, input logic [31:0] imp);
        pending_words.push_back('{action: act, document: doc, matched: mt, importance: imp});
    endfunction

    // Mostly inserts with occasional read-outs; a few clears and unused codes
    function automatic pending_word_t random_word();
        pending_word_t w;
        int unsigned   p;
        int unsigned   q;
        p = $urandom_range(0, 99);
        q = $urandom_range(0, 9);
        w.document = $urandom;
        w.matched  = 8'($urandom_range(0, 255));
        // narrow importances force ties and equal-to-lightest drops
        if (q < 4)
            w.importance = $urandom_range(0, 20);
        else if (q < 8)
            w.importance = $urandom;
        else if (q == 8)
            w.importance = 32'hFFFF_FFFF;
        else
            w.importance = 32'h0;
        if (p < 4)
            w.action = ACT_CLEAR;
        else if (p < 16)
            w.action = ACT_READ;
        else if (p < 19)
            w.action = ACT_SPARE;
        else
            w.action = ACT_INSERT;
        return w;
    endfunction

    // Hold until every pending word is sent and every expected word has arrived
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_valid || expected_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        cfg_valid     <= 1'b1;
        cfg_hit_limit <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        apply_limit(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Sender: offer words from the pending queue, hold each until taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_words
        pending_word_t nxt;
        logic          offer;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            offer = s_valid && !s_ready;
            if (s_valid && s_ready)
                rank_word('{action: s_action, document: s_document,
                            matched: s_matched, importance: s_importance});
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_words.size() != 0) begin
                    nxt          = pending_words.pop_front();
                    s_action     <= nxt.action;
                    s_document   <= nxt.document;
                    s_matched    <= nxt.matched;
                    s_importance <= nxt.importance;
                    offer        = 1'b1;
                    send_gap     <= s_gaps_on ? pick_gap() : 0;
                end
            end
            s_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_gaps_on && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result word with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_words
        ranked_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_words.pop_front();
                if (m_hit_valid !== want.hit_valid)
                    report_mismatch($sformatf("hit_valid %0d, want %0d",
                                              m_hit_valid, want.hit_valid));
                if (m_rank !== want.rank)
                    report_mismatch($sformatf("rank %0d, want %0d", m_rank, want.rank));
                if (m_hit_document !== want.document)
                    report_mismatch($sformatf("hit_document %h, want %h",
                                              m_hit_document, want.document));
                if (m_hit_matched !== want.matched)
                    report_mismatch($sformatf("hit_matched %h, want %h",
                                              m_hit_matched, want.matched));
                if (m_hit_importance !== want.importance)
                    report_mismatch($sformatf("hit_importance %h, want %h",
                                              m_hit_importance, want.importance));
                if (m_held !== want.held)
                    report_mismatch($sformatf("held %0d, want %0d", m_held, want.held));
                if (m_accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %0d, want %0d",
                                              m_accepted, want.accepted));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", m_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed words, then random phases over several limits
    // ------------------------------------------------------------------
    initial begin : run_phases
        logic [LIMIT_W-1:0] phase_limits [11];
        phase_limits = '{7'd127, 7'd64, 7'd16, 7'd17, 7'd2, 7'd1, 7'd0,
                         7'd8, 7'd16, 7'd100, 7'd5};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limit of 16: empty read-out, field extremes, ties at the bottom
        queue_word(ACT_READ,   32'h0,         8'h00, 32'h0);
        queue_word(ACT_INSERT, 32'h0,         8'h00, 32'h0);
        queue_word(ACT_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_word(ACT_INSERT, 32'h1,         8'h01, 32'h0);
        queue_word(ACT_INSERT, 32'h2,         8'h07, 32'h8000_0000);
        queue_word(ACT_SPARE,  32'hA5A5_5A5A, 8'hC3, 32'h1234_5678);
        queue_word(ACT_READ,   32'h0,         8'h00, 32'h0);
        queue_word(ACT_CLEAR,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        queue_word(ACT_READ,   32'h0,         8'h00, 32'h0);

        // Limit of three: ties go behind, equal-to-lightest dropped, lightest falls off
        write_limit(7'd3);
        queue_word(ACT_INSERT, 32'd10, 8'd1, 32'd5);
        queue_word(ACT_INSERT, 32'd11, 8'd2, 32'd7);
        queue_word(ACT_INSERT, 32'd12, 8'd3, 32'd7);
        queue_word(ACT_INSERT, 32'd13, 8'd4, 32'd5);
        queue_word(ACT_INSERT, 32'd14, 8'd5, 32'd9);
        queue_word(ACT_INSERT, 32'd15, 8'd6, 32'd0);
        queue_word(ACT_READ,   32'd0,  8'd0, 32'd0);

        // Lower the limit below the count: the list is cut to one
        write_limit(7'd1);
        queue_word(ACT_READ,   32'd0,  8'd0,  32'd0);
        queue_word(ACT_INSERT, 32'd16, 8'd7,  32'd9);
        queue_word(ACT_INSERT, 32'd17, 8'd8,  32'hFFFF_FFFF);
        queue_word(ACT_READ,   32'd0,  8'd0,  32'd0);

        // Limit of zero: every insert is dropped
        write_limit(7'd0);
        queue_word(ACT_INSERT, 32'd18, 8'd9, 32'hFFFF_FFFF);
        queue_word(ACT_READ,   32'd0,  8'd0, 32'd0);
        queue_word(ACT_CLEAR,  32'd0,  8'd0, 32'd0);

        for (int p = 0; p < 11; p++) begin
            write_limit(phase_limits[p]);
            // one phase of back-to-back traffic on both sides, one with a steady sender
            s_gaps_on = (p != 3 && p != 6);
            m_gaps_on = (p != 3);
            for (int n = 0; n < 36; n++)
                pending_words.push_back(random_word());
            // hold the receiver off while the sender keeps offering, so the input stalls
            if (p == 1) begin
                @(posedge aclk);
                hold_seq <= hold_seq + 1;
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
